// ===== sv/hqlm_pkg.sv =====
// shared types and constants of the two-level queue lock manager
// no dependencies
package hqlm_pkg;

  localparam int unsigned THREADS     = 64;
  localparam int unsigned SOCKETS     = 4;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned TID_W       = $clog2(THREADS);
  localparam int unsigned SID_W       = $clog2(SOCKETS);

  localparam logic [TID_W:0]       NO_THREAD    = (TID_W + 1)'(THREADS);
  localparam logic [SID_W:0]       NO_SOCKET    = (SID_W + 1)'(SOCKETS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_FIRST  = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] THRESH_RESET = COUNT_WIDTH'(64);

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_TRYLOCK = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_BAD     = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    EV_GRANT    = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_BUSY     = 3'd2,
    EV_RELEASED = 3'd3,
    EV_ERROR    = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LOCAL  = 2'd1,
    PH_GLOBAL = 2'd2,
    PH_HOLD   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TID_W-1:0] thread_id;
    logic [SID_W-1:0] socket;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0]       thread_id_res;
    logic [2:0]             event_res;
    logic [COUNT_WIDTH-1:0] cohort_count;
    logic                   last;
  } res_t;

  // one word of the per-thread table
  typedef struct packed {
    phase_e                 phase;
    logic [SID_W-1:0]       socket;
    logic [TID_W:0]         next;
    logic [COUNT_WIDTH-1:0] count;
  } thr_ent_t;

endpackage

// ===== sv/hierarchical_queue_lock_manager.sv =====
// two-level queue lock manager: thread table in a synchronous ram, socket queues in flops
// depends on hqlm_pkg
// a bad selector word is answered in the cycle after start, others after a ram read
// busy holds off the next word until the request is done, set by dependent ram reads
// results come at most one per cycle on res_valid_o, the receiver cannot stall
// reset: all threads idle, all queues empty, threshold 64; no clearing pass,
// per-thread valid flops make an unwritten entry read as idle
module hierarchical_queue_lock_manager import hqlm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  req_t                   req_i,
  output logic                   res_valid_o,
  output res_t                   res_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [COUNT_WIDTH-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for start
    S_RD_T,  // requester entry is on the read port
    S_LINK,  // queue predecessor entry on the read port, link it
    S_COH,   // local successor, cohort pass
    S_GW,    // waiter of next socket, grant it
    S_GS     // local successor re-requests global
  } state_e;

  state_e state_q, state_d;
  req_t   cur_q, cur_d;

  logic [COUNT_WIDTH-1:0] thr_q, thr_d;

  // socket level state
  logic [TID_W:0]   local_tail_q [SOCKETS];
  logic [TID_W:0]   local_tail_d [SOCKETS];
  logic [TID_W-1:0] sock_waiter_q [SOCKETS];
  logic [TID_W-1:0] sock_waiter_d [SOCKETS];
  logic [SID_W:0]   global_next_q [SOCKETS];
  logic [SID_W:0]   global_next_d [SOCKETS];
  logic [SID_W:0]   global_tail_q, global_tail_d;

  // release context
  logic [SID_W-1:0]       hs_q, hs_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [TID_W:0]         succ_q, succ_d;
  logic [TID_W-1:0]       x_q, x_d;

  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  // thread table ram
  thr_ent_t         mem_q [THREADS];
  logic             vld_q [THREADS];
  logic             mem_we;
  logic [TID_W-1:0] mem_wa, mem_ra;
  thr_ent_t         mem_wd, rd_data_q, rd_ent;
  logic             rd_vld_q;
  phase_e           rd_phase;

  // scratch
  logic [TID_W:0]   prev_t;
  logic [SID_W:0]   gn;
  logic             succ_v, gn_v;
  logic [TID_W-1:0] w_id;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign rd_ent   = rd_data_q;
  assign rd_phase = rd_vld_q ? rd_data_q.phase : PH_IDLE;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[mem_ra];
    rd_vld_q  <= vld_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < THREADS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (mem_we) begin
      vld_q[mem_wa] <= 1'b1;
    end
  end

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    thr_d         = thr_q;
    local_tail_d  = local_tail_q;
    sock_waiter_d = sock_waiter_q;
    global_next_d = global_next_q;
    global_tail_d = global_tail_q;
    hs_d          = hs_q;
    cnt_d         = cnt_q;
    succ_d        = succ_q;
    x_d           = x_q;
    res_valid_d   = 1'b0;
    res_d         = res_q;
    mem_we        = 1'b0;
    mem_wa        = cur_q.thread_id;
    mem_wd        = rd_ent;
    mem_ra        = cur_q.thread_id;
    prev_t        = local_tail_q[cur_q.socket];
    gn            = global_next_q[hs_q];
    succ_v        = 1'b0;
    gn_v          = 1'b0;
    w_id          = x_q;

    if (cfg_valid_i) begin
      thr_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cur_d  = req_i;
          mem_ra = req_i.thread_id;
          if (req_i.req_type == REQ_BAD) begin
            res_valid_d = 1'b1;
            res_d       = '{req_i.thread_id, EV_ERROR, '0, 1'b1};
          end else begin
            state_d = S_RD_T;
          end
        end
      end

      S_RD_T: begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        res_d       = '{cur_q.thread_id, EV_ERROR, '0, 1'b1};
        case (cur_q.req_type)
          REQ_ACQUIRE: begin
            if (rd_phase == PH_IDLE) begin
              mem_we        = 1'b1;
              mem_wd.socket = cur_q.socket;
              mem_wd.next   = NO_THREAD;
              local_tail_d[cur_q.socket] = {1'b0, cur_q.thread_id};
              if (!prev_t[TID_W]) begin
                // join the socket queue behind prev
                mem_wd.phase = PH_LOCAL;
                res_d        = '{cur_q.thread_id, EV_QUEUED, '0, 1'b1};
                x_d          = prev_t[TID_W-1:0];
                mem_ra       = prev_t[TID_W-1:0];
                state_d      = S_LINK;
              end else begin
                // first of its socket: ask for the global lock
                mem_wd.count                = COUNT_FIRST;
                global_next_d[cur_q.socket] = NO_SOCKET;
                global_tail_d               = {1'b0, cur_q.socket};
                if (global_tail_q[SID_W]) begin
                  mem_wd.phase = PH_HOLD;
                  res_d = '{cur_q.thread_id, EV_GRANT, COUNT_FIRST, 1'b1};
                end else begin
                  global_next_d[global_tail_q[SID_W-1:0]] = {1'b0, cur_q.socket};
                  sock_waiter_d[cur_q.socket] = cur_q.thread_id;
                  mem_wd.phase = PH_GLOBAL;
                  res_d = '{cur_q.thread_id, EV_QUEUED, '0, 1'b1};
                end
              end
            end
          end
          REQ_TRYLOCK: begin
            if (rd_phase == PH_IDLE) begin
              if (!prev_t[TID_W] || !global_tail_q[SID_W]) begin
                res_d = '{cur_q.thread_id, EV_BUSY, '0, 1'b1};
              end else begin
                mem_we = 1'b1;
                mem_wd = '{PH_HOLD, cur_q.socket, NO_THREAD, COUNT_FIRST};
                local_tail_d[cur_q.socket]  = {1'b0, cur_q.thread_id};
                global_next_d[cur_q.socket] = NO_SOCKET;
                global_tail_d               = {1'b0, cur_q.socket};
                res_d = '{cur_q.thread_id, EV_GRANT, COUNT_FIRST, 1'b1};
              end
            end
          end
          REQ_RELEASE: begin
            if (rd_phase == PH_HOLD) begin
              mem_we       = 1'b1;
              mem_wd.phase = PH_IDLE;
              hs_d         = rd_ent.socket;
              cnt_d        = rd_ent.count;
              succ_d       = rd_ent.next;
              succ_v       = !rd_ent.next[TID_W];
              gn           = global_next_q[rd_ent.socket];
              gn_v         = !gn[SID_W];
              w_id         = sock_waiter_q[gn[SID_W-1:0]];
              res_d = '{cur_q.thread_id, EV_RELEASED, '0, !succ_v && !gn_v};
              if (rd_ent.count < thr_q && succ_v) begin
                // cohort pass inside the socket
                mem_ra  = rd_ent.next[TID_W-1:0];
                state_d = S_COH;
              end else if (gn_v) begin
                x_d     = w_id;
                mem_ra  = w_id;
                state_d = S_GW;
              end else begin
                if (global_tail_q == {1'b0, rd_ent.socket}) begin
                  global_tail_d = NO_SOCKET;
                end
                if (succ_v) begin
                  mem_ra  = rd_ent.next[TID_W-1:0];
                  state_d = S_GS;
                end else if (local_tail_q[rd_ent.socket] == {1'b0, cur_q.thread_id}) begin
                  local_tail_d[rd_ent.socket] = NO_THREAD;
                end
              end
            end
          end
          default: ;
        endcase
      end

      S_LINK: begin
        mem_we      = 1'b1;
        mem_wa      = x_q;
        mem_wd.next = {1'b0, cur_q.thread_id};
        state_d     = S_IDLE;
      end

      S_COH: begin
        mem_we       = 1'b1;
        mem_wa       = succ_q[TID_W-1:0];
        mem_wd.phase = PH_HOLD;
        mem_wd.count = cnt_q + COUNT_WIDTH'(1);
        res_valid_d  = 1'b1;
        res_d = '{succ_q[TID_W-1:0], EV_GRANT, cnt_q + COUNT_WIDTH'(1), 1'b1};
        state_d      = S_IDLE;
      end

      S_GW: begin
        mem_we       = 1'b1;
        mem_wa       = x_q;
        mem_wd.phase = PH_HOLD;
        res_valid_d  = 1'b1;
        res_d        = '{x_q, EV_GRANT, rd_ent.count, succ_q[TID_W]};
        if (!succ_q[TID_W]) begin
          mem_ra  = succ_q[TID_W-1:0];
          state_d = S_GS;
        end else begin
          if (local_tail_q[hs_q] == {1'b0, cur_q.thread_id}) begin
            local_tail_d[hs_q] = NO_THREAD;
          end
          state_d = S_IDLE;
        end
      end

      S_GS: begin
        // socket re-enters the global queue headed by its successor
        mem_we              = 1'b1;
        mem_wa              = succ_q[TID_W-1:0];
        mem_wd.count        = COUNT_FIRST;
        global_next_d[hs_q] = NO_SOCKET;
        global_tail_d       = {1'b0, hs_q};
        res_valid_d         = 1'b1;
        if (global_tail_q[SID_W]) begin
          mem_wd.phase = PH_HOLD;
          res_d = '{succ_q[TID_W-1:0], EV_GRANT, COUNT_FIRST, 1'b1};
        end else begin
          global_next_d[global_tail_q[SID_W-1:0]] = {1'b0, hs_q};
          sock_waiter_d[hs_q] = succ_q[TID_W-1:0];
          mem_wd.phase = PH_GLOBAL;
          res_d = '{succ_q[TID_W-1:0], EV_QUEUED, '0, 1'b1};
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      thr_q         <= THRESH_RESET;
      global_tail_q <= NO_SOCKET;
      res_valid_q   <= 1'b0;
      for (int i = 0; i < SOCKETS; i++) begin
        local_tail_q[i] <= NO_THREAD;
      end
    end else begin
      state_q       <= state_d;
      thr_q         <= thr_d;
      global_tail_q <= global_tail_d;
      res_valid_q   <= res_valid_d;
      local_tail_q  <= local_tail_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cur_q         <= cur_d;
    hs_q          <= hs_d;
    cnt_q         <= cnt_d;
    succ_q        <= succ_d;
    x_q           <= x_d;
    res_q         <= res_d;
    sock_waiter_q <= sock_waiter_d;
    global_next_q <= global_next_d;
  end

endmodule

// ===== tb/hierarchical_queue_lock_manager_tb.sv =====
// self-checking bench for the two-level queue lock manager: random and directed lock traffic
// predicts every result word from its own lock-table model; depends on hqlm_pkg and the block
`timescale 1ns / 1ps
module hierarchical_queue_lock_manager_tb;
  import hqlm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  req_t                   req_i = '0;
  logic                   res_valid_o;
  res_t                   res_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [COUNT_WIDTH-1:0] cfg_data_i = '0;

  hierarchical_queue_lock_manager u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // lock table as the bench sees it
  int unsigned threshold;
  int unsigned sock_tail[SOCKETS];
  int unsigned thr_next[THREADS];
  phase_e      thr_phase[THREADS];
  int unsigned thr_count[THREADS];
  int unsigned thr_sock[THREADS];
  int unsigned sock_waiter[SOCKETS];
  int unsigned glob_tail;
  int unsigned glob_next[SOCKETS];

  req_t pending_reqs[$];
  res_t expected_words[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   idle_free = 1'b0;   // long stretch with no sender idling

  task automatic push_word(int unsigned tid, event_e ev, int unsigned cnt);
    res_t w;
    w.thread_id_res = tid[TID_W-1:0];
    w.event_res     = ev;
    w.cohort_count  = cnt[COUNT_WIDTH-1:0];
    w.last          = 1'b0;
    expected_words.push_back(w);
  endtask

  function automatic bit ask_global(int unsigned s, int unsigned t);
    int unsigned prev;
    prev = glob_tail;
    thr_count[t] = COUNT_FIRST;
    glob_next[s] = SOCKETS;
    glob_tail = s;
    if (prev >= SOCKETS) begin
      thr_phase[t] = PH_HOLD;
      return 1'b1;
    end
    glob_next[prev] = s;
    sock_waiter[s] = t;
    thr_phase[t] = PH_GLOBAL;
    return 1'b0;
  endfunction

  // works out the words one accepted request causes, updates the table
  task automatic predict_lock_words(req_t r);
    int unsigned t, s, prev, hs, c, succ, gn, w;
    t = r.thread_id;
    s = r.socket;
    if (r.req_type == REQ_BAD) begin
      push_word(t, EV_ERROR, 0);
    end else if (r.req_type == REQ_ACQUIRE) begin
      if (thr_phase[t] != PH_IDLE) begin
        push_word(t, EV_ERROR, 0);
      end else begin
        prev = sock_tail[s];
        thr_sock[t] = s;
        thr_next[t] = THREADS;
        sock_tail[s] = t;
        if (prev < THREADS) begin
          thr_next[prev] = t;
          thr_phase[t] = PH_LOCAL;
          push_word(t, EV_QUEUED, 0);
        end else if (ask_global(s, t)) begin
          push_word(t, EV_GRANT, COUNT_FIRST);
        end else begin
          push_word(t, EV_QUEUED, 0);
        end
      end
    end else if (r.req_type == REQ_TRYLOCK) begin
      if (thr_phase[t] != PH_IDLE) begin
        push_word(t, EV_ERROR, 0);
      end else if (sock_tail[s] < THREADS || glob_tail < SOCKETS) begin
        push_word(t, EV_BUSY, 0);
      end else begin
        thr_sock[t] = s;
        thr_next[t] = THREADS;
        sock_tail[s] = t;
        void'(ask_global(s, t));
        push_word(t, EV_GRANT, COUNT_FIRST);
      end
    end else begin
      if (thr_phase[t] != PH_HOLD) begin
        push_word(t, EV_ERROR, 0);
      end else begin
        hs = thr_sock[t];
        c = thr_count[t] & 16'hffff;
        succ = thr_next[t];
        thr_phase[t] = PH_IDLE;
        push_word(t, EV_RELEASED, 0);
        if (c < threshold && succ < THREADS) begin
          // pass within the cohort
          thr_count[succ] = (c + 1) & 16'hffff;
          thr_phase[succ] = PH_HOLD;
          push_word(succ, EV_GRANT, thr_count[succ]);
        end else begin
          gn = glob_next[hs];
          if (gn < SOCKETS) begin
            w = sock_waiter[gn];
            if (w < THREADS) begin
              thr_phase[w] = PH_HOLD;
              push_word(w, EV_GRANT, thr_count[w]);
            end
          end else if (glob_tail == hs) begin
            glob_tail = SOCKETS;
          end
          if (succ < THREADS) begin
            if (ask_global(hs, succ)) push_word(succ, EV_GRANT, COUNT_FIRST);
            else push_word(succ, EV_QUEUED, 0);
          end else if (sock_tail[hs] == t) begin
            sock_tail[hs] = THREADS;
          end
        end
      end
    end
    expected_words[$].last = 1'b1;
  endtask

  // driver: one request word per accepted start, random idle gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_lock_words(req_i);
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 && (idle_free || $urandom_range(99) >= 34)) begin
          start <= 1'b1;
          req_i <= pending_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word against the oldest expectation
  always @(posedge clk_i) begin
    res_t exp_w;
    cycles <= cycles + 1;
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %p", res_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (res_o !== exp_w) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("expected %p got %p", exp_w, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic req_t mk(req_type_e k, int unsigned t, int unsigned s);
    req_t r;
    r.req_type = k;
    r.thread_id = t[TID_W-1:0];
    r.socket = s[SID_W-1:0];
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_threshold(int unsigned v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[COUNT_WIDTH-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    threshold = v;
    cfg_valid_i <= 1'b0;
  endtask

  // random traffic: mostly acquire/release of plausible threads, some noise
  task automatic random_phase(int n);
    int unsigned k, t;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      t = $urandom_range(63);
      if (k < 45) pending_reqs.push_back(mk(REQ_ACQUIRE, t & 15, $urandom_range(3)));
      else if (k < 55) pending_reqs.push_back(mk(REQ_TRYLOCK, t, $urandom_range(3)));
      else if (k < 93) pending_reqs.push_back(mk(REQ_RELEASE, t & 15, $urandom_range(3)));
      else if (k < 97) pending_reqs.push_back(mk(REQ_BAD, t, $urandom_range(3)));
      else pending_reqs.push_back(mk(REQ_RELEASE, t, $urandom_range(3)));
    end
  endtask

  initial begin
    threshold = THRESH_RESET;
    glob_tail = SOCKETS;
    for (int i = 0; i < SOCKETS; i++) begin
      sock_tail[i] = THREADS;
      sock_waiter[i] = 0;
      glob_next[i] = 0;
    end
    for (int i = 0; i < THREADS; i++) begin
      thr_next[i] = 0;
      thr_phase[i] = PH_IDLE;
      thr_count[i] = 0;
      thr_sock[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every request kind, misuse, busy trylock, cohort hand-off
    write_threshold(2);
    pending_reqs.push_back(mk(REQ_TRYLOCK, 63, 3));
    pending_reqs.push_back(mk(REQ_TRYLOCK, 0, 3));
    pending_reqs.push_back(mk(REQ_ACQUIRE, 63, 3));
    pending_reqs.push_back(mk(REQ_ACQUIRE, 1, 3));
    pending_reqs.push_back(mk(REQ_ACQUIRE, 2, 3));
    pending_reqs.push_back(mk(REQ_ACQUIRE, 3, 0));
    pending_reqs.push_back(mk(REQ_TRYLOCK, 4, 0));
    pending_reqs.push_back(mk(REQ_TRYLOCK, 5, 1));
    pending_reqs.push_back(mk(REQ_RELEASE, 1, 0));
    pending_reqs.push_back(mk(REQ_BAD, 42, 2));
    pending_reqs.push_back(mk(REQ_RELEASE, 63, 0));
    pending_reqs.push_back(mk(REQ_RELEASE, 1, 0));
    pending_reqs.push_back(mk(REQ_RELEASE, 3, 0));
    pending_reqs.push_back(mk(REQ_RELEASE, 2, 0));
    pending_reqs.push_back(mk(REQ_RELEASE, 0, 0));
    pending_reqs.push_back(mk(REQ_RELEASE, 63, 0));
    write_threshold(0);
    pending_reqs.push_back(mk(REQ_ACQUIRE, 10, 1));
    pending_reqs.push_back(mk(REQ_ACQUIRE, 11, 1));
    pending_reqs.push_back(mk(REQ_RELEASE, 10, 1));
    pending_reqs.push_back(mk(REQ_RELEASE, 11, 1));

    write_threshold(1);
    random_phase(100);
    write_threshold(65535);
    idle_free = 1'b1;
    random_phase(100);
    wait_drained();
    idle_free = 1'b0;
    write_threshold(3);
    random_phase(100);
    write_threshold(64);
    random_phase(100);
    wait_drained();

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
